/* src/cmfb_pkg.sv */
// shared types, register indexes and helpers for the clipped mirrored frame blit
package cmfb_pkg;

    localparam int DIM_BITS   = 13;
    localparam int COORD_BITS = 18;
    localparam int MAX_DIM    = 4096;
    localparam int SETTLE     = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [2:0] {
        REG_SRC_LEFT   = 3'd0,
        REG_SRC_TOP    = 3'd1,
        REG_SRC_RIGHT  = 3'd2,
        REG_SRC_BOTTOM = 3'd3,
        REG_DEST_LEFT  = 3'd4,
        REG_DEST_TOP   = 3'd5,
        REG_FRAME_DIMS = 3'd6,
        REG_COPY_MODE  = 3'd7
    } reg_index_t;

    localparam logic [2:0] FMT_YUV    = 3'd1;
    localparam logic [2:0] FMT_BAYER1 = 3'd2;
    localparam logic [2:0] FMT_BAYER2 = 3'd3;
    localparam logic [2:0] FMT_BAYER3 = 3'd4;
    localparam logic [2:0] FMT_BAYER4 = 3'd5;
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    typedef struct packed {
        logic [1:0]  plane;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [7:0]  pixel_value;
    } in_t;

    typedef struct packed {
        logic        write_enable;
        logic [1:0]  dest_plane;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [7:0]  pixel_out;
        logic [2:0]  new_format;
    } out_t;

    // per-pixel bounds and offsets worked out once from the registers
    typedef struct packed {
        logic       ok;
        logic       yuv;
        logic       mx;
        logic       my;
        logic [2:0] fmt_out;
        coord_t     y_lo;
        coord_t     y_hi;
        coord_t     y_add;
        coord_t     y_sub;
        coord_t     x_lo;
        coord_t     x_hi;
        coord_t     x_add;
        coord_t     x_sub;
        coord_t     c_lo;
        coord_t     c_hi;
        coord_t     c_add;
        coord_t     c_sub;
    } geom_t;

    function automatic coord_t sext14(input logic [13:0] v);
        sext14 = {{(COORD_BITS-14){v[13]}}, v};
    endfunction

    // mirror x swaps phases 1<->2 and 3<->4, mirror y swaps 1<->3 and 2<->4
    function automatic logic [2:0] mirror_fmt(input logic [2:0] fmt, input logic mx,
                                              input logic my);
        logic [2:0] f;
        f = fmt;
        if (fmt inside {[FMT_BAYER1:FMT_BAYER4]})
        begin
            if (mx)
            begin
                case (f)
                    FMT_BAYER1: f = FMT_BAYER2;
                    FMT_BAYER2: f = FMT_BAYER1;
                    FMT_BAYER3: f = FMT_BAYER4;
                    FMT_BAYER4: f = FMT_BAYER3;
                    default:    f = f;
                endcase
            end
            if (my)
            begin
                case (f)
                    FMT_BAYER1: f = FMT_BAYER3;
                    FMT_BAYER2: f = FMT_BAYER4;
                    FMT_BAYER3: f = FMT_BAYER1;
                    FMT_BAYER4: f = FMT_BAYER2;
                    default:    f = f;
                endcase
            end
        end
        mirror_fmt = f;
    endfunction

endpackage

/* src/clipped_mirrored_frame_blit.sv */
// top level: clipped, mirrored rectangle blit, one source pixel per word
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_data  (cmfb_pkg::in_t)
//  out      output     out_valid/out_stall  out_data (cmfb_pkg::out_t)
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word per cycle while neither out_stall nor settling holds the input; a result
// passes through the input register, then the result register behind the mapping logic.
// after reset and after every register write the input stalls while the
// four-stage geometry pipeline in cmfb_cfg settles.
// out_stall holds the result register; the input register keeps taking a
// word while a result waits and, settling apart, stalls only when both are full.
module clipped_mirrored_frame_blit #(
    parameter int MAX_DIM = cmfb_pkg::MAX_DIM
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  cmfb_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output cmfb_pkg::out_t                   out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [4*cmfb_pkg::DIM_BITS-1:0]  cfg_data
);

    cmfb_pkg::geom_t geom;
    cmfb_pkg::in_t   s1_data_reg;
    cmfb_pkg::out_t  out_data_reg, map_res;
    logic            s1_valid_reg, s1_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            busy, advance, s1_load, accept;

    cmfb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .busy      (busy)
    );

    cmfb_map u_map (
        .geom (geom),
        .pix  (s1_data_reg),
        .res  (map_res)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || advance;
    assign in_stall = busy || !s1_load;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = s1_load ? accept : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= map_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/cmfb_cfg.sv */
// configuration registers and the registered pipeline that derives the clip geometry
module cmfb_cfg #(
    parameter int MAX_DIM = cmfb_pkg::MAX_DIM
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [4*cmfb_pkg::DIM_BITS-1:0]      cfg_data,
    output cmfb_pkg::geom_t                      geom,
    output logic                                 busy
);

    localparam cmfb_pkg::coord_t MAX_C = cmfb_pkg::coord_t'(MAX_DIM);
    localparam int DB = cmfb_pkg::DIM_BITS;

    typedef struct packed {
        cmfb_pkg::coord_t sx1, sx2, sy1, sy2, dx, dy, sw, sh, dw, dh;
        logic [2:0]       fmt;
        logic             mx, my;
    } stage_a_t;

    typedef struct packed {
        logic             rej;
        cmfb_pkg::coord_t sx1, sx2, sy1, sy2, dx, dy, dw, dh;
        logic [2:0]       fmt;
        logic             mx, my;
    } stage_b_t;

    typedef struct packed {
        logic             ok;
        cmfb_pkg::coord_t sx1, sy1, dx, dy, lw, zh;
        logic [2:0]       fmt_out;
        logic             yuv, mx, my;
    } stage_c_t;

    logic [13:0]       src_left_reg, src_top_reg, src_right_reg, src_bottom_reg;
    logic [13:0]       dest_left_reg, dest_top_reg;
    logic [4*DB-1:0]   frame_dims_reg;
    logic [4:0]        copy_mode_reg;
    logic [2:0]        settle_reg, settle_next;
    stage_a_t          a_reg, a_next;
    stage_b_t          b_reg, b_next;
    stage_c_t          c_reg, c_next;
    cmfb_pkg::geom_t   geom_reg, geom_next;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign busy      = (settle_reg != 3'd0);
    assign geom      = geom_reg;

    function automatic cmfb_pkg::coord_t clamp_dim(input logic [DB-1:0] d);
        cmfb_pkg::coord_t v;
        v = cmfb_pkg::coord_t'({{(cmfb_pkg::COORD_BITS-DB){1'b0}}, d});
        clamp_dim = (v > MAX_C) ? MAX_C : v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_left_reg   <= '0;
            src_top_reg    <= '0;
            src_right_reg  <= '0;
            src_bottom_reg <= '0;
            dest_left_reg  <= '0;
            dest_top_reg   <= '0;
            frame_dims_reg <= '0;
            copy_mode_reg  <= '0;
            settle_reg     <= 3'(cmfb_pkg::SETTLE);
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write)
            begin
                case (cmfb_pkg::reg_index_t'(cfg_index))
                    cmfb_pkg::REG_SRC_LEFT:   src_left_reg   <= cfg_data[13:0];
                    cmfb_pkg::REG_SRC_TOP:    src_top_reg    <= cfg_data[13:0];
                    cmfb_pkg::REG_SRC_RIGHT:  src_right_reg  <= cfg_data[13:0];
                    cmfb_pkg::REG_SRC_BOTTOM: src_bottom_reg <= cfg_data[13:0];
                    cmfb_pkg::REG_DEST_LEFT:  dest_left_reg  <= cfg_data[13:0];
                    cmfb_pkg::REG_DEST_TOP:   dest_top_reg   <= cfg_data[13:0];
                    cmfb_pkg::REG_FRAME_DIMS: frame_dims_reg <= cfg_data;
                    cmfb_pkg::REG_COPY_MODE:  copy_mode_reg  <= cfg_data[4:0];
                    default:                  copy_mode_reg  <= copy_mode_reg;
                endcase
            end
        end
    end

    // hold off pixels until a register change has reached the geometry stage
    always_comb
    begin
        if (cfg_write)
        begin
            settle_next = 3'(cmfb_pkg::SETTLE);
        end
        else if (settle_reg != 3'd0)
        begin
            settle_next = settle_reg - 3'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // stage a: sign extend, clamp sizes, bayer origin parity shift
    always_comb
    begin
        logic bayer;
        a_next.fmt = copy_mode_reg[4:2];
        a_next.mx  = copy_mode_reg[0];
        a_next.my  = copy_mode_reg[1];
        bayer      = (copy_mode_reg[4:2] inside
                      {[cmfb_pkg::FMT_BAYER1:cmfb_pkg::FMT_BAYER4]});
        a_next.sx1 = cmfb_pkg::sext14(src_left_reg);
        a_next.sy1 = cmfb_pkg::sext14(src_top_reg);
        a_next.sx2 = cmfb_pkg::sext14(src_right_reg);
        a_next.sy2 = cmfb_pkg::sext14(src_bottom_reg);
        a_next.dx  = cmfb_pkg::sext14(dest_left_reg)
                   + cmfb_pkg::coord_t'(bayer && (src_left_reg[0] ^ dest_left_reg[0]));
        a_next.dy  = cmfb_pkg::sext14(dest_top_reg)
                   + cmfb_pkg::coord_t'(bayer && (src_top_reg[0] ^ dest_top_reg[0]));
        a_next.sw  = clamp_dim(frame_dims_reg[DB-1:0]);
        a_next.sh  = clamp_dim(frame_dims_reg[2*DB-1:DB]);
        a_next.dw  = clamp_dim(frame_dims_reg[3*DB-1:2*DB]);
        a_next.dh  = clamp_dim(frame_dims_reg[4*DB-1:3*DB]);
    end

    // stage b: reject test and clipping against both frames
    always_comb
    begin
        cmfb_pkg::coord_t sx1a, dxa, sy1a, dya;
        b_next.fmt = a_reg.fmt;
        b_next.mx  = a_reg.mx;
        b_next.my  = a_reg.my;
        b_next.dw  = a_reg.dw;
        b_next.dh  = a_reg.dh;
        b_next.rej = (a_reg.dx >= a_reg.dw)
                  || (a_reg.dx + (a_reg.sx2 - a_reg.sx1 + 18'sd1) < 0)
                  || (a_reg.dy >= a_reg.dh)
                  || (a_reg.dy + (a_reg.sy2 - a_reg.sy1 + 18'sd1) < 0);
        b_next.sx2 = (a_reg.sx2 > a_reg.sw - 18'sd1) ? a_reg.sw - 18'sd1 : a_reg.sx2;
        b_next.sy2 = (a_reg.sy2 > a_reg.sh - 18'sd1) ? a_reg.sh - 18'sd1 : a_reg.sy2;
        sx1a = (a_reg.dx < 0) ? a_reg.sx1 - a_reg.dx : a_reg.sx1;
        dxa  = (a_reg.dx < 0) ? '0 : a_reg.dx;
        sy1a = (a_reg.dy < 0) ? a_reg.sy1 - a_reg.dy : a_reg.sy1;
        dya  = (a_reg.dy < 0) ? '0 : a_reg.dy;
        b_next.dx  = (sx1a < 0) ? dxa - sx1a : dxa;
        b_next.sx1 = (sx1a < 0) ? '0 : sx1a;
        b_next.dy  = (sy1a < 0) ? dya - sy1a : dya;
        b_next.sy1 = (sy1a < 0) ? '0 : sy1a;
    end

    // stage c: empty zone test, clipped width and height, output format
    always_comb
    begin
        logic             empty;
        cmfb_pkg::coord_t lw0, zh0;
        empty = (b_reg.sx1 > b_reg.sx2) || (b_reg.sy1 > b_reg.sy2);
        lw0   = b_reg.sx2 - b_reg.sx1 + 18'sd1;
        zh0   = b_reg.sy2 - b_reg.sy1 + 18'sd1;
        c_next.lw  = (b_reg.dx + lw0 >= b_reg.dw) ? b_reg.dw - b_reg.dx : lw0;
        c_next.zh  = (b_reg.dy + zh0 >= b_reg.dh) ? b_reg.dh - b_reg.dy : zh0;
        c_next.ok  = !b_reg.rej && !empty;
        c_next.fmt_out = (b_reg.rej || empty) ? b_reg.fmt
                       : cmfb_pkg::mirror_fmt(b_reg.fmt, b_reg.mx, b_reg.my);
        c_next.yuv = (b_reg.fmt == cmfb_pkg::FMT_YUV);
        c_next.mx  = b_reg.mx;
        c_next.my  = b_reg.my;
        c_next.sx1 = b_reg.sx1;
        c_next.sy1 = b_reg.sy1;
        c_next.dx  = b_reg.dx;
        c_next.dy  = b_reg.dy;
    end

    // stage d: bounds and offsets so each pixel needs an add per coordinate and four range compares
    always_comb
    begin
        cmfb_pkg::coord_t half, csx, cdx;
        half = c_reg.lw >>> 1;
        csx  = c_reg.sx1 >>> 1;
        cdx  = c_reg.dx >>> 1;
        geom_next.ok      = c_reg.ok && (c_reg.lw > 0) && (c_reg.zh > 0);
        geom_next.yuv     = c_reg.yuv;
        geom_next.mx      = c_reg.mx;
        geom_next.my      = c_reg.my;
        geom_next.fmt_out = c_reg.fmt_out;
        geom_next.y_lo    = c_reg.sy1;
        geom_next.y_hi    = c_reg.sy1 + c_reg.zh - 18'sd1;
        geom_next.y_add   = c_reg.dy - c_reg.sy1;
        geom_next.y_sub   = c_reg.dy + c_reg.zh - 18'sd1 + c_reg.sy1;
        geom_next.x_lo    = c_reg.sx1;
        geom_next.x_hi    = c_reg.sx1 + c_reg.lw - 18'sd1;
        geom_next.x_add   = c_reg.dx - c_reg.sx1;
        geom_next.x_sub   = c_reg.dx + c_reg.lw - 18'sd1 + c_reg.sx1;
        geom_next.c_lo    = csx;
        geom_next.c_hi    = csx + half - 18'sd1;
        geom_next.c_add   = cdx - csx;
        geom_next.c_sub   = cdx + half - 18'sd1 + csx;
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        geom_reg <= geom_next;
    end

endmodule

/* src/cmfb_map.sv */
// per-pixel destination mapping: row and column range checks and mirroring
module cmfb_map (
    input  cmfb_pkg::geom_t geom,
    input  cmfb_pkg::in_t   pix,
    output cmfb_pkg::out_t  res
);

    localparam int CB = cmfb_pkg::COORD_BITS;

    always_comb
    begin
        logic             luma, chroma, yok, xok, we;
        cmfb_pkg::coord_t j, px, jref, col, row;
        luma   = (pix.plane == cmfb_pkg::PLANE_Y);
        chroma = geom.yuv && ((pix.plane == cmfb_pkg::PLANE_U) ||
                              (pix.plane == cmfb_pkg::PLANE_V));
        px = cmfb_pkg::coord_t'({{(CB-12){1'b0}}, pix.pix_x});
        // chroma row r sits on luma row 2r
        j  = luma ? cmfb_pkg::coord_t'({{(CB-12){1'b0}}, pix.pix_y})
                  : cmfb_pkg::coord_t'({{(CB-13){1'b0}}, pix.pix_y, 1'b0});
        yok  = geom.ok && (j >= geom.y_lo) && (j <= geom.y_hi);
        jref = geom.my ? geom.y_sub - j : geom.y_add + j;
        if (luma)
        begin
            xok = (px >= geom.x_lo) && (px <= geom.x_hi);
            col = geom.mx ? geom.x_sub - px : geom.x_add + px;
            row = jref;
        end
        else
        begin
            xok = (px >= geom.c_lo) && (px <= geom.c_hi);
            col = geom.mx ? geom.c_sub - px : geom.c_add + px;
            row = jref >>> 1;
        end
        we = (luma || chroma) && yok && xok;

        res.new_format   = geom.fmt_out;
        res.write_enable = we;
        res.dest_plane   = we ? pix.plane : 2'd0;
        res.dest_x       = we ? col[11:0] : 12'd0;
        res.dest_y       = we ? row[11:0] : 12'd0;
        res.pixel_out    = we ? pix.pixel_value : 8'd0;
    end

endmodule

/* test/clipped_mirrored_frame_blit_tb.sv */
// self-checking testbench for the clipped mirrored frame blit
module clipped_mirrored_frame_blit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ERR_PRINT_MAX = 50;

    localparam logic [2:0] FMT_GREY   = 3'd0;
    localparam logic [2:0] FMT_SPARE6 = 3'd6;
    localparam logic [2:0] FMT_SPARE7 = 3'd7;
    localparam logic [1:0] PLANE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_WRITE,
        JOB_DRAIN
    } job_kind_t;

    typedef struct packed {
        job_kind_t            kind;
        cmfb_pkg::in_t        pix;
        logic [7:0]           gap;
        cmfb_pkg::reg_index_t idx;
        logic [51:0]          value;
    } job_t;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    cmfb_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    cmfb_pkg::out_t out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [2:0]     cfg_index = '0;
    logic [51:0]    cfg_data = '0;

    job_t           job_q[$];
    cmfb_pkg::out_t landing_q[$];
    int   landings_due = 0;
    int   error_cnt = 0;
    int   cycle_cnt = 0;

    // driver bookkeeping
    int hold_left = 0;
    int quiet_cycles = 0;

    // receiver idling
    int stall_left = 0;
    int stall_level = 0;
    int level_left = 0;

    // register copy used for prediction
    logic [13:0] geom_reg [0:5];
    logic [51:0] cur_dims;
    logic [4:0]  cur_mode;

    // rectangle the stimulus aims at in the current phase
    int aim_sl, aim_st, aim_sr, aim_sb;
    logic aim_yuv;

    clipped_mirrored_frame_blit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int as_int14(input logic [13:0] v);
        return int'($signed(v));
    endfunction

    function automatic int clamp_dim(input logic [12:0] d);
        return (int'(d) > cmfb_pkg::MAX_DIM) ? cmfb_pkg::MAX_DIM : int'(d);
    endfunction

    // where one source pixel lands under the current registers
    function automatic cmfb_pkg::out_t land_pixel(input cmfb_pkg::in_t p);
        cmfb_pkg::out_t r;
        logic       mx, my, bayer;
        logic [2:0] fmt, f;
        int sw, sh, dw, dh, sx1, sy1, sx2, sy2, dx, dy;
        int px, py, lw, zh, j, jref, off, half, col, row;
        r = '0;
        mx = cur_mode[0];
        my = cur_mode[1];
        fmt = cur_mode[4:2];
        bayer = (fmt >= cmfb_pkg::FMT_BAYER1) && (fmt <= cmfb_pkg::FMT_BAYER4);
        sw = clamp_dim(cur_dims[12:0]);
        sh = clamp_dim(cur_dims[25:13]);
        dw = clamp_dim(cur_dims[38:26]);
        dh = clamp_dim(cur_dims[51:39]);
        sx1 = as_int14(geom_reg[cmfb_pkg::REG_SRC_LEFT]);
        sy1 = as_int14(geom_reg[cmfb_pkg::REG_SRC_TOP]);
        sx2 = as_int14(geom_reg[cmfb_pkg::REG_SRC_RIGHT]);
        sy2 = as_int14(geom_reg[cmfb_pkg::REG_SRC_BOTTOM]);
        dx = as_int14(geom_reg[cmfb_pkg::REG_DEST_LEFT]);
        dy = as_int14(geom_reg[cmfb_pkg::REG_DEST_TOP]);
        px = int'(p.pix_x);
        py = int'(p.pix_y);
        r.new_format = fmt;

        // bayer keeps the destination origin on the source parity
        if (bayer)
        begin
            if (sx1[0] != dx[0])
                dx = dx + 1;
            if (sy1[0] != dy[0])
                dy = dy + 1;
        end
        if (dx >= dw || dx + (sx2 - sx1 + 1) < 0 || dy >= dh || dy + (sy2 - sy1 + 1) < 0)
            return r;
        if (sx2 > sw - 1)
            sx2 = sw - 1;
        if (sy2 > sh - 1)
            sy2 = sh - 1;
        if (dx < 0)
        begin
            sx1 = sx1 - dx;
            dx = 0;
        end
        if (dy < 0)
        begin
            sy1 = sy1 - dy;
            dy = 0;
        end
        if (sx1 < 0)
        begin
            dx = dx - sx1;
            sx1 = 0;
        end
        if (sy1 < 0)
        begin
            dy = dy - sy1;
            sy1 = 0;
        end
        if (sx1 > sx2 || sy1 > sy2)
            return r;

        f = fmt;
        if (bayer)
        begin
            if (mx)
            begin
                case (f)
                    cmfb_pkg::FMT_BAYER1: f = cmfb_pkg::FMT_BAYER2;
                    cmfb_pkg::FMT_BAYER2: f = cmfb_pkg::FMT_BAYER1;
                    cmfb_pkg::FMT_BAYER3: f = cmfb_pkg::FMT_BAYER4;
                    default:              f = cmfb_pkg::FMT_BAYER3;
                endcase
            end
            if (my)
            begin
                case (f)
                    cmfb_pkg::FMT_BAYER1: f = cmfb_pkg::FMT_BAYER3;
                    cmfb_pkg::FMT_BAYER2: f = cmfb_pkg::FMT_BAYER4;
                    cmfb_pkg::FMT_BAYER3: f = cmfb_pkg::FMT_BAYER1;
                    default:              f = cmfb_pkg::FMT_BAYER2;
                endcase
            end
        end
        r.new_format = f;

        lw = sx2 - sx1 + 1;
        zh = sy2 - sy1 + 1;
        if (dx + lw >= dw)
            lw = dw - dx;
        if (dy + zh >= dh)
            zh = dh - dy;

        // chroma row r pairs with luma row 2r
        if (p.plane == cmfb_pkg::PLANE_Y)
            j = py;
        else if ((p.plane == cmfb_pkg::PLANE_U || p.plane == cmfb_pkg::PLANE_V)
                 && fmt == cmfb_pkg::FMT_YUV)
            j = 2 * py;
        else
            return r;
        if (zh <= 0 || lw <= 0 || j < sy1 || j > sy1 + zh - 1)
            return r;
        jref = my ? dy + zh - 1 - (j - sy1) : dy + (j - sy1);

        if (p.plane == cmfb_pkg::PLANE_Y)
        begin
            off = px - sx1;
            if (off < 0 || off >= lw)
                return r;
            col = mx ? dx + lw - 1 - off : dx + off;
            row = jref;
        end
        else
        begin
            half = lw / 2;
            off = px - sx1 / 2;
            if (off < 0 || off >= half)
                return r;
            col = mx ? dx / 2 + half - 1 - off : dx / 2 + off;
            row = jref / 2;
        end
        r.write_enable = 1'b1;
        r.dest_plane = p.plane;
        r.dest_x = col[11:0];
        r.dest_y = row[11:0];
        r.pixel_out = p.pixel_value;
        return r;
    endfunction

    // idle length: level 0 never idles, higher levels idle more often
    function automatic int gap_len(input int level);
        int r;
        r = int'($urandom_range(0, 99));
        if (level == 0 || r >= level * 30)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 75)
            return int'($urandom_range(1, 3));
        if (r < 95)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 50));
    endfunction

    function automatic int rand_dim();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 3)
            return 0;
        if (r < 70)
            return int'($urandom_range(16, 120));
        if (r < 90)
            return int'($urandom_range(121, 4096));
        return int'($urandom_range(4097, 8191));
    endfunction

    function automatic int rect_span();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 80)
            return int'($urandom_range(1, 40));
        if (r < 95)
            return int'($urandom_range(41, 400));
        return int'($urandom_range(1, 8191));
    endfunction

    // occasionally replace a register value by one anywhere in its range
    function automatic int maybe_wild(input int v);
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 2)
            return -8192;
        if (r < 4)
            return 8191;
        if (r < 7)
            return int'($urandom_range(0, 16383)) - 8192;
        return v;
    endfunction

    function automatic logic [11:0] pick_near(input int lo, input int hi);
        int          a, b;
        logic [11:0] v;
        a = (lo < 0 ? 0 : lo) - 2;
        b = (hi > 4095 ? 4095 : hi) + 2;
        if (a < 0)
            a = 0;
        if (b > 4095)
            b = 4095;
        if (a > b)
            v = 12'($urandom_range(0, 4095));
        else
            v = 12'($urandom_range(b, a));
        return v;
    endfunction

    function automatic logic [51:0] dims_of(input int sw, input int sh, input int dw,
                                            input int dh);
        return {dh[12:0], dw[12:0], sh[12:0], sw[12:0]};
    endfunction

    function automatic logic [4:0] mode_of(input logic [2:0] fmt, input logic mx,
                                           input logic my);
        return {fmt, my, mx};
    endfunction

    task automatic push_pixel(input logic [1:0] pl, input int x, input int y, input int v,
                              input int gap);
        job_t w;
        w = '0;
        w.kind = JOB_PIXEL;
        w.pix.plane = pl;
        w.pix.pix_x = x[11:0];
        w.pix.pix_y = y[11:0];
        w.pix.pixel_value = v[7:0];
        w.gap = gap[7:0];
        job_q.push_back(w);
    endtask

    task automatic push_write(input cmfb_pkg::reg_index_t idx, input logic [51:0] v);
        job_t w;
        w = '0;
        w.kind = JOB_WRITE;
        w.idx = idx;
        w.value = v;
        job_q.push_back(w);
    endtask

    task automatic push_drain();
        job_t w;
        w = '0;
        w.kind = JOB_DRAIN;
        job_q.push_back(w);
    endtask

    task automatic push_setup(input int sl, input int st, input int sr, input int sb,
                              input int dl, input int dt, input logic [51:0] dims,
                              input logic [4:0] mode);
        push_write(cmfb_pkg::REG_SRC_LEFT,   {38'd0, sl[13:0]});
        push_write(cmfb_pkg::REG_SRC_TOP,    {38'd0, st[13:0]});
        push_write(cmfb_pkg::REG_SRC_RIGHT,  {38'd0, sr[13:0]});
        push_write(cmfb_pkg::REG_SRC_BOTTOM, {38'd0, sb[13:0]});
        push_write(cmfb_pkg::REG_DEST_LEFT,  {38'd0, dl[13:0]});
        push_write(cmfb_pkg::REG_DEST_TOP,   {38'd0, dt[13:0]});
        push_write(cmfb_pkg::REG_FRAME_DIMS, dims);
        push_write(cmfb_pkg::REG_COPY_MODE,  {47'd0, mode});
        aim_sl = sl;
        aim_st = st;
        aim_sr = sr;
        aim_sb = sb;
        aim_yuv = (mode[4:2] == cmfb_pkg::FMT_YUV);
    endtask

    task automatic push_random_setup();
        int         sw, sh, dw, dh, sl, st, sr, sb, dl, dt;
        logic [4:0] mode;
        sw = rand_dim();
        sh = rand_dim();
        dw = rand_dim();
        dh = rand_dim();
        sl = int'($urandom_range(0, (sw > 4096 ? 4096 : sw) + 8)) - 8;
        st = int'($urandom_range(0, (sh > 4096 ? 4096 : sh) + 8)) - 8;
        sr = sl + rect_span() - 1;
        sb = st + rect_span() - 1;
        if (sr > 8191)
            sr = 8191;
        if (sb > 8191)
            sb = 8191;
        dl = int'($urandom_range(0, (dw > 4096 ? 4096 : dw) + 16)) - 16;
        dt = int'($urandom_range(0, (dh > 4096 ? 4096 : dh) + 16)) - 16;
        mode = 5'($urandom_range(0, 23));
        if ($urandom_range(0, 99) < 30)
            mode[4:2] = cmfb_pkg::FMT_YUV;
        push_setup(maybe_wild(sl), maybe_wild(st), maybe_wild(sr), maybe_wild(sb),
                   maybe_wild(dl), maybe_wild(dt), dims_of(sw, sh, dw, dh), mode);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            if (error_cnt < ERR_PRINT_MAX)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            error_cnt = error_cnt + 1;
        end
    endtask

    // sender: one pixel word or register write at a time from the job queue
    always @(posedge clk or negedge rst_n)
    begin : driver
        job_t nxt;
        logic nv, ncv;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            hold_left = 0;
            quiet_cycles = 0;
        end
        else
        begin
            nv = in_valid && in_stall;
            ncv = cfg_valid && !cfg_ready;
            if (in_valid || landings_due != 0)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (!nv && !ncv)
            begin
                if (hold_left > 0)
                    hold_left = hold_left - 1;
                else if (job_q.size() != 0)
                begin
                    nxt = job_q[0];
                    // writes and drains wait until the block has gone quiet
                    if (nxt.kind == JOB_PIXEL || quiet_cycles > cmfb_pkg::SETTLE + 2)
                    begin
                        nxt = job_q.pop_front();
                        case (nxt.kind)
                            JOB_PIXEL:
                            begin
                                in_data <= nxt.pix;
                                nv = 1'b1;
                                hold_left = int'(nxt.gap);
                            end
                            JOB_WRITE:
                            begin
                                cfg_index <= nxt.idx;
                                cfg_data <= nxt.value;
                                ncv = 1'b1;
                            end
                            default:
                            begin
                                quiet_cycles = 0;
                            end
                        endcase
                    end
                end
            end
            in_valid <= nv;
            cfg_valid <= ncv;
        end
    end

    // receiver: tracks register writes, predicts landings and checks results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        cmfb_pkg::out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            landings_due <= 0;
            for (int i = 0; i < 6; i++)
                geom_reg[i] = '0;
            cur_dims = '0;
            cur_mode = '0;
            stall_left = 0;
            level_left = 0;
            stall_level = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cmfb_pkg::REG_FRAME_DIMS: cur_dims = cfg_data;
                    cmfb_pkg::REG_COPY_MODE:  cur_mode = cfg_data[4:0];
                    default:                  geom_reg[cfg_index] = cfg_data[13:0];
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (landing_q.size() == 0)
                begin
                    if (error_cnt < ERR_PRINT_MAX)
                        $display("%0t ns: unexpected result word, expected none, actual %h",
                                 $time, out_data);
                    error_cnt = error_cnt + 1;
                end
                else
                begin
                    want = landing_q.pop_front();
                    check_field("write_enable", int'(want.write_enable),
                                int'(out_data.write_enable));
                    check_field("dest_plane", int'(want.dest_plane), int'(out_data.dest_plane));
                    check_field("dest_x", int'(want.dest_x), int'(out_data.dest_x));
                    check_field("dest_y", int'(want.dest_y), int'(out_data.dest_y));
                    check_field("pixel_out", int'(want.pixel_out), int'(out_data.pixel_out));
                    check_field("new_format", int'(want.new_format),
                                int'(out_data.new_format));
                end
            end
            if (in_valid && !in_stall)
                landing_q.push_back(land_pixel(in_data));
            landings_due <= landing_q.size();

            if (level_left == 0)
            begin
                stall_level = $urandom_range(0, 2);
                level_left = 400;
            end
            else
                level_left = level_left - 1;
            if (stall_left == 0)
                stall_left = gap_len(stall_level);
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int          r, lvl;
        logic [1:0]  pl;
        logic [11:0] x, y;

        // reset registers: everything is rejected
        push_pixel(cmfb_pkg::PLANE_Y, 0, 0, 0, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_V, 4095, 4095, 255, gap_len(1));

        // yuv with both mirrors, small frames
        push_setup(2, 3, 9, 8, 5, 1, dims_of(16, 16, 20, 12),
                   mode_of(cmfb_pkg::FMT_YUV, 1'b1, 1'b1));
        push_pixel(cmfb_pkg::PLANE_Y, 2, 3, 8'h11, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_Y, 9, 8, 8'hEE, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_Y, 1, 3, 8'h5A, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_Y, 10, 8, 8'hA5, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_U, 1, 2, 8'h80, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_V, 4, 1, 8'h7F, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_V, 4, 4, 8'h01, gap_len(1));
        push_pixel(PLANE_UNUSED, 2, 3, 8'hFF, gap_len(1));

        // bayer with origins already on matching parity, negative destination, frame sizes clamped
        push_setup(1, -2, 8191, 8191, -3, 0, {52{1'b1}},
                   mode_of(cmfb_pkg::FMT_BAYER2, 1'b1, 1'b0));
        push_pixel(cmfb_pkg::PLANE_Y, 4095, 4095, 255, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_Y, 0, 0, 0, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_Y, 1, 0, 8'h33, gap_len(1));
        push_pixel(cmfb_pkg::PLANE_U, 5, 5, 8'h44, gap_len(1));

        // spare format codes behave as grey
        push_setup(0, 0, 3, 3, 0, 0, dims_of(4, 4, 4, 4), mode_of(FMT_SPARE7, 1'b0, 1'b1));
        push_pixel(cmfb_pkg::PLANE_Y, 1, 2, 8'h55, gap_len(1));
        push_write(cmfb_pkg::REG_COPY_MODE, {47'd0, mode_of(FMT_SPARE6, 1'b1, 1'b0)});
        push_pixel(cmfb_pkg::PLANE_Y, 3, 3, 8'h66, gap_len(1));

        // rectangle wholly outside the destination
        push_setup(2, 3, 9, 8, 20, 1, dims_of(16, 16, 20, 12), mode_of(FMT_GREY, 1'b0, 1'b0));
        push_pixel(cmfb_pkg::PLANE_Y, 2, 3, 8'h77, gap_len(1));
        // clipping pushes the origin past the destination edge
        push_setup(-5, 0, 10, 5, 17, 0, dims_of(16, 16, 20, 12),
                   mode_of(cmfb_pkg::FMT_BAYER1, 1'b1, 1'b1));
        push_pixel(cmfb_pkg::PLANE_Y, 0, 3, 8'h88, gap_len(1));
        // empty rectangle
        push_write(cmfb_pkg::REG_SRC_LEFT, {38'd0, 14'd9});
        push_write(cmfb_pkg::REG_SRC_RIGHT, {38'd0, 14'd2});
        push_pixel(cmfb_pkg::PLANE_Y, 5, 2, 8'h99, gap_len(1));

        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 0)
                push_setup(8191, 8191, 8191, 8191, 8191, 8191, {52{1'b1}}, 5'd23);
            else if (ph == 1)
                push_setup(-8192, -8192, -8192, -8192, -8192, -8192, '0, 5'd0);
            else
                push_random_setup();
            lvl = ph % 3;
            for (int n = 0; n < 110; n++)
            begin
                if ((ph == 4 || ph == 9) && n == 55)
                    push_drain();
                r = int'($urandom_range(0, 99));
                if (r < 15)
                begin
                    pl = ($urandom_range(0, 99) == 0) ? PLANE_UNUSED
                                                      : 2'($urandom_range(0, 2));
                    x = 12'($urandom_range(0, 4095));
                    y = 12'($urandom_range(0, 4095));
                end
                else if (r < 55 && aim_yuv || r < 20)
                begin
                    pl = $urandom_range(0, 1) ? cmfb_pkg::PLANE_V : cmfb_pkg::PLANE_U;
                    x = pick_near(aim_sl / 2, aim_sr / 2);
                    y = pick_near(aim_st / 2, aim_sb / 2);
                end
                else
                begin
                    pl = cmfb_pkg::PLANE_Y;
                    x = pick_near(aim_sl, aim_sr);
                    y = pick_near(aim_st, aim_sb);
                end
                push_pixel(pl, int'(x), int'(y), int'($urandom_range(0, 255)), gap_len(lvl));
            end
        end

        while (job_q.size() != 0 || in_valid || cfg_valid || landings_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (error_cnt == 0 && landing_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
src/cmfb_pkg.sv
src/cmfb_cfg.sv
src/cmfb_map.sv
src/clipped_mirrored_frame_blit.sv
test/clipped_mirrored_frame_blit_tb.sv
